>>> rtl/core/htpd_pkg.sv
// Package for the humidity/temperature poll decoder.
// Types, action codes and scaling constants shared by all rtl/core modules.
// No dependencies.
`default_nettype none

package htpd_pkg;

    localparam int unsigned RAW_W       = 20;   // raw sensor sample width
    localparam int unsigned HUM_W       = 14;
    localparam int unsigned TEMP_W      = 15;
    localparam int unsigned INTERVAL_W  = 16;
    localparam int unsigned TIMER_W     = 17;
    localparam int unsigned PADDR_W     = 3;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;
    localparam int unsigned           BUSY_BIT       = 7;
    localparam logic [13:0]           HUM_SCALE      = 14'd10000;
    localparam logic [14:0]           TEMP_SCALE     = 15'd20000;
    localparam logic [TEMP_W-1:0]     TEMP_OFFSET    = 15'd5000;

    // register index (paddr / 4)
    localparam logic REG_POLL_INTERVAL = 1'b0;

    typedef enum logic [2:0] {
        ACT_IDLE      = 3'd0,
        ACT_TRIG_SENT = 3'd1,
        ACT_READ_BUSY = 3'd2,
        ACT_NEW_SAMPLE= 3'd3,
        ACT_READ_ERR  = 3'd4,
        ACT_TRIG_ERR  = 3'd5
    } htpd_action_t;

    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic        bus_error;
        logic [7:0]  status_byte;
        logic [7:0]  read_byte_one;
        logic [7:0]  read_byte_two;
        logic [7:0]  read_byte_three;
        logic [7:0]  read_byte_four;
        logic [7:0]  read_byte_five;
    } htpd_item_t;

    typedef struct packed {
        htpd_action_t        action;
        logic [HUM_W-1:0]    humidity_centi;
        logic [TEMP_W-1:0]   temperature_centi;
    } htpd_result_t;

endpackage

`default_nettype wire

>>> rtl/core/htpd_cfg.sv
// APB-style configuration register block: holds the poll interval.
// Depends on htpd_pkg.
`default_nettype none

module htpd_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [htpd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output logic      [htpd_pkg::INTERVAL_W-1:0] poll_interval_ms
);
    import htpd_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [INTERVAL_W-1:0] interval_next;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        interval_next = interval_reg;
        if (wr_en && (paddr[2] == REG_POLL_INTERVAL))
        begin
            interval_next = pwdata[INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            interval_reg <= interval_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_POLL_INTERVAL)
        begin
            prdata = {{(32-INTERVAL_W){1'b0}}, interval_reg};
        end
    end

    assign poll_interval_ms = interval_reg;

endmodule

`default_nettype wire

>>> rtl/core/htpd_in_stage.sv
// Input register stage: captures one item from the slave stream.
// Depends on htpd_pkg.
`default_nettype none

module htpd_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire htpd_pkg::htpd_item_t in_item,
    output logic                      item_valid,
    input  wire logic                 item_ready,
    output htpd_pkg::htpd_item_t      item
);
    import htpd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    htpd_item_t item_reg;

    // accept while empty or while the held item moves on this cycle
    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/core/htpd_decode.sv
// Poll decode stage: timer, phase tracking, sample unpack and scaling,
// result register. Depends on htpd_pkg.
`default_nettype none

module htpd_decode (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [htpd_pkg::INTERVAL_W-1:0] poll_interval_ms,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire htpd_pkg::htpd_item_t            item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output htpd_pkg::htpd_result_t               result
);
    import htpd_pkg::*;

    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               awaiting_reg, awaiting_next;
    logic [HUM_W-1:0]   hum_reg, hum_next;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    htpd_action_t       action_reg, action_next;
    logic               out_valid_reg, out_valid_next;

    logic               advance;
    logic [TIMER_W-1:0] timer_sum;
    logic               phase_step;
    logic [RAW_W-1:0]   hraw;
    logic [RAW_W-1:0]   traw;
    logic [33:0]        hprod;
    logic [34:0]        tprod;
    logic [TEMP_W-1:0]  temp_scaled;

    assign item_ready = !out_valid_reg || out_ready;
    assign advance    = item_valid && item_ready;

    // timer stays below the interval, so the sum never exceeds 17 bits
    assign timer_sum  = timer_reg + {1'b0, item.elapsed_ms};
    assign phase_step = timer_sum >= {1'b0, poll_interval_ms};

    assign hraw = {item.read_byte_one, item.read_byte_two, item.read_byte_three[7:4]};
    assign traw = {item.read_byte_three[3:0], item.read_byte_four, item.read_byte_five};

    assign hprod       = 34'(hraw) * 34'(HUM_SCALE);
    assign tprod       = 35'(traw) * 35'(TEMP_SCALE);
    assign temp_scaled = tprod[34:RAW_W] - TEMP_OFFSET;

    always_comb
    begin
        timer_next    = timer_reg;
        awaiting_next = awaiting_reg;
        hum_next      = hum_reg;
        temp_next     = temp_reg;
        action_next   = action_reg;
        if (advance)
        begin
            timer_next  = timer_sum;
            action_next = ACT_IDLE;
            if (phase_step)
            begin
                timer_next = '0;
                priority if (!awaiting_reg)
                begin
                    awaiting_next = 1'b1;
                    action_next   = item.bus_error ? ACT_TRIG_ERR : ACT_TRIG_SENT;
                end
                else if (item.bus_error)
                begin
                    action_next = ACT_READ_ERR;
                end
                else if (item.status_byte[BUSY_BIT])
                begin
                    action_next = ACT_READ_BUSY;
                end
                else
                begin
                    awaiting_next = 1'b0;
                    hum_next      = hprod[33:RAW_W];
                    temp_next     = temp_scaled;
                    action_next   = ACT_NEW_SAMPLE;
                end
            end
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg     <= '0;
            awaiting_reg  <= 1'b0;
            hum_reg       <= '0;
            temp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timer_reg     <= timer_next;
            awaiting_reg  <= awaiting_next;
            hum_reg       <= hum_next;
            temp_reg      <= temp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
    end

    // last values only change when a new result is loaded, so they
    // double as the held output payload
    assign out_valid                = out_valid_reg;
    assign result.action            = action_reg;
    assign result.humidity_centi    = hum_reg;
    assign result.temperature_centi = temp_reg;

endmodule

`default_nettype wire

>>> rtl/core/humidity_temperature_poll_decode.sv
// Humidity/temperature sensor poll decoder: one item in, one result out, one item
// per clock sustained. An item passes an input register and then a single pass of
// timer add/compare, phase logic and the two constant-scaling multiplies into the
// result register, which holds the result until the output side takes it; the rate
// is set only by the output side taking results. Results report the action
// code (tuser) and the latest humidity and temperature in hundredths (tdata). The
// poll interval register sits at APB address 0 and resets to 100 ms.
// Depends on htpd_pkg, htpd_cfg, htpd_in_stage, htpd_decode.
`default_nettype none

module humidity_temperature_poll_decode (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] elapsed_ms, [23:16] status_byte, [31:24] read_byte_one,
    // [39:32] read_byte_two, [47:40] read_byte_three, [55:48] read_byte_four,
    // [63:56] read_byte_five
    input  wire logic [63:0]                   s_tdata,
    // [0] bus_error
    input  wire logic [0:0]                    s_tuser,
    // master stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [13:0] humidity_centi, [28:14] temperature_centi, [31:29] zero
    output logic      [31:0]                   m_tdata,
    // [2:0] action
    output logic      [2:0]                    m_tuser,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [htpd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import htpd_pkg::*;

    logic [INTERVAL_W-1:0] poll_interval_ms;
    htpd_item_t            in_item;
    htpd_item_t            item;
    logic                  item_valid;
    logic                  item_ready;
    htpd_result_t          result;

    assign in_item.elapsed_ms      = s_tdata[15:0];
    assign in_item.bus_error       = s_tuser[0];
    assign in_item.status_byte     = s_tdata[23:16];
    assign in_item.read_byte_one   = s_tdata[31:24];
    assign in_item.read_byte_two   = s_tdata[39:32];
    assign in_item.read_byte_three = s_tdata[47:40];
    assign in_item.read_byte_four  = s_tdata[55:48];
    assign in_item.read_byte_five  = s_tdata[63:56];

    htpd_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .poll_interval_ms (poll_interval_ms)
    );

    htpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    htpd_decode u_decode (
        .clk              (clk),
        .rst_n            (rst_n),
        .poll_interval_ms (poll_interval_ms),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .result           (result)
    );

    assign m_tdata = {3'b000, result.temperature_centi, result.humidity_centi};
    assign m_tuser = result.action;

endmodule

`default_nettype wire

>>> rtl/core/htpd_checker.sv
// Port-level checker for the poll decoder, bound to the top level.
// Depends on htpd_pkg and humidity_temperature_poll_decode.
`default_nettype none

module htpd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        pready
);
    import htpd_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // scaled humidity never exceeds 99.99 percent
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[13:0] <= 14'd9999)
        else $error("humidity out of range");

    // temperature stays inside -50.00 .. 149.99
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[28:14]) >= -15'sd5000) &&
                     ($signed(m_tdata[28:14]) <= 15'sd14999))
        else $error("temperature out of range");

    // readings only change on a result that reports a new sample
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> (m_tdata[28:0] == $past(m_tdata[28:0])) ||
            (m_tuser == ACT_NEW_SAMPLE))
        else $error("readings changed without a new sample");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind humidity_temperature_poll_decode htpd_checker u_htpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

`default_nettype wire
